// ===== hdl/bms_pkg.sv =====
// ----------------------------------------------------------------------------
// bms_pkg: shared types and constants of the melody sequencer
// request codes, note store entry layout, tone period table
// ----------------------------------------------------------------------------
package bms_pkg;

  // timer input clock and note store size
  localparam int unsigned TIMER_CLOCK_HZ = 84000000;
  localparam int unsigned STORE_DEPTH    = 256;
  localparam int unsigned STORE_AW       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam int unsigned PRESCALE_DIV = 320;
  localparam logic [2:0]  REST_NOTE    = 3'd7;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_START = 2'd1,
    REQ_STOP  = 2'd2,
    REQ_TICK  = 2'd3
  } req_t;

  typedef logic [8:0]  pos_t;
  typedef logic [15:0] word16_t;

  // one note store entry
  typedef struct packed {
    logic [2:0] note;
    word16_t    dur;
  } entry_t;

  // one input word as seen by the core
  typedef struct packed {
    req_t       req;
    logic [7:0] idx;
    logic [2:0] note;
    word16_t    dur;
    pos_t       cnt;
  } item_t;

  // one result word
  typedef struct packed {
    logic    playing;
    word16_t period;
    word16_t compare;
    pos_t    position;
    logic    finished;
  } result_t;

  // period = q - 1, zero when q is zero, saturated to 16 bits
  function automatic word16_t sat_period(input longint unsigned q);
    word16_t r;
    if (q == 0) begin
      r = '0;
    end else if (q - 1 > 64'd65535) begin
      r = 16'hFFFF;
    end else begin
      r = q[15:0] - 16'd1;
    end
    return r;
  endfunction

  // tone frequencies in centihertz, C5..B5
  localparam longint unsigned CLK_X100 = longint'(TIMER_CLOCK_HZ) * 100;
  localparam longint unsigned Q_C5 = CLK_X100 / (longint'(PRESCALE_DIV) * 52325);
  localparam longint unsigned Q_D5 = CLK_X100 / (longint'(PRESCALE_DIV) * 58733);
  localparam longint unsigned Q_E5 = CLK_X100 / (longint'(PRESCALE_DIV) * 65925);
  localparam longint unsigned Q_F5 = CLK_X100 / (longint'(PRESCALE_DIV) * 69846);
  localparam longint unsigned Q_G5 = CLK_X100 / (longint'(PRESCALE_DIV) * 78399);
  localparam longint unsigned Q_A5 = CLK_X100 / (longint'(PRESCALE_DIV) * 88000);
  localparam longint unsigned Q_B5 = CLK_X100 / (longint'(PRESCALE_DIV) * 98777);

  localparam word16_t TONE_PERIOD [7] = '{
    sat_period(Q_C5), sat_period(Q_D5), sat_period(Q_E5), sat_period(Q_F5),
    sat_period(Q_G5), sat_period(Q_A5), sat_period(Q_B5)
  };

endpackage

// ===== hdl/bms_if.sv =====
// ----------------------------------------------------------------------------
// bms_if: valid/ready channels of the melody sequencer
// one interface for request words, one for result words
// ----------------------------------------------------------------------------
interface bms_in_if;
  logic             valid;
  logic             ready;
  bms_pkg::req_t    req_type;
  logic [7:0]       entry_index;
  logic [2:0]       entry_note;
  logic [15:0]      entry_duration;
  logic [8:0]       note_count;

  modport source (output valid, req_type, entry_index, entry_note, entry_duration,
                  note_count, input ready);
  modport sink   (input valid, req_type, entry_index, entry_note, entry_duration,
                  note_count, output ready);
endinterface

interface bms_out_if;
  logic        valid;
  logic        ready;
  logic        playing;
  logic [15:0] period_value;
  logic [15:0] compare_value;
  logic [8:0]  note_position;
  logic        finished;

  modport source (output valid, playing, period_value, compare_value, note_position,
                  finished, input ready);
  modport sink   (input valid, playing, period_value, compare_value, note_position,
                  finished, output ready);
endinterface

// ===== hdl/buzzer_melody_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// buzzer_melody_sequencer_unit: melody player for a pwm buzzer
// note store, millisecond timing and tone period/compare generation
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake           word
//  in_ch     in    valid/ready         req_type, entry_index, entry_note,
//                                      entry_duration, note_count
//  out_ch    out   valid/ready         playing, period_value, compare_value,
//                                      note_position, finished
//
//  one request word per cycle sustained while out_ch keeps taking result words;
//  each result passes from the input register through the update pass into the
//  result register, from which out_ch takes it
//  the update pass reads two prefetched note store entries, so it never waits
//  on the store read port
//  rst_n is synchronous; playback state is cleared, the note store is not
//  a stalled out_ch holds its word while a new word still enters the input
//  register; in_ch.ready drops only when both registers are full and stalled
//
module buzzer_melody_sequencer_unit (
  input logic   clk,
  input logic   rst_n,
  bms_in_if.sink    in_ch,
  bms_out_if.source out_ch
);
  import bms_pkg::*;

  // input register
  logic    in_vld_r, in_vld_nxt;
  item_t   item_r;

  // result register
  logic    out_vld_r, out_vld_nxt;
  result_t out_r;

  logic    advance;     // update pass may run this cycle
  logic    go;          // a word is processed into the result register
  logic    in_take;     // in_ch handshake
  result_t res;

  assign advance = !out_vld_r || out_ch.ready;
  assign go      = in_vld_r && advance;

  // the input register is free when empty or being drained this cycle
  assign in_ch.ready = !in_vld_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (go) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (go) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    // payload registers load without reset
    if (in_take) begin
      item_r <= '{req: in_ch.req_type, idx: in_ch.entry_index, note: in_ch.entry_note,
                  dur: in_ch.entry_duration, cnt: in_ch.note_count};
    end
    if (go) begin
      out_r <= res;
    end
  end

  // playback state, note store and tone lookup
  bms_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (item_r),
    .res   (res)
  );

  assign out_ch.valid         = out_vld_r;
  assign out_ch.playing       = out_r.playing;
  assign out_ch.period_value  = out_r.period;
  assign out_ch.compare_value = out_r.compare;
  assign out_ch.note_position = out_r.position;
  assign out_ch.finished      = out_r.finished;

`ifndef SYNTH
  // the word that ends the melody never reports playing
  a_fin_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.finished) |-> !out_r.playing)
    else $error("finished word still reports playing");

  // a sounding compare only exists while playing
  a_cmp_playing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.compare != 16'd0) |-> out_r.playing)
    else $error("nonzero compare while stopped");

  // a word held in the input register is not lost while the result side stalls
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !advance) |=> in_vld_r)
    else $error("input word dropped under stall");
`endif

endmodule

// ===== hdl/bms_ram.sv =====
// ----------------------------------------------------------------------------
// bms_ram: generic ram, one write port, two registered read ports
// a read at the address being written returns the new data
// ----------------------------------------------------------------------------
module bms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr_a,
  output logic [WIDTH-1:0] rd_data_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= (wr_en && wr_addr == rd_addr_a) ? wr_data : mem[rd_addr_a];
    rd_data_b <= (wr_en && wr_addr == rd_addr_b) ? wr_data : mem[rd_addr_b];
  end

endmodule

// ===== hdl/bms_core.sv =====
// ----------------------------------------------------------------------------
// bms_core: playback state and one-pass update per request word
// keeps the current and following store entries prefetched
// ----------------------------------------------------------------------------
module bms_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  bms_pkg::item_t   item,
  output bms_pkg::result_t res
);
  import bms_pkg::*;

  pos_t       pos_r, pos_nxt;
  word16_t    elapsed_r, elapsed_nxt;
  pos_t       total_r, total_nxt;
  logic       active_r, active_nxt;
  word16_t    period_r, period_nxt;
  word16_t    compare_r, compare_nxt;
  entry_t     e0_r, e0_nxt;
  logic       fin;

  logic       wr_en;
  entry_t     wr_entry;
  entry_t     cur_raw, next_raw;
  logic       cur_ok, next_ok;
  word16_t    cur_dur;
  logic [2:0] next_note;
  pos_t       pos_inc;
  pos_t       rd_b_pos;
  word16_t    elapsed_inc;
  logic       load_ok;

  // store writes, loads beyond the store are dropped
  assign load_ok  = ({24'd0, item.idx} < 32'(STORE_DEPTH));
  assign wr_en    = go && (item.req == REQ_LOAD) && load_ok;
  assign wr_entry = '{note: item.note, dur: item.dur};

  assign rd_b_pos = pos_nxt + 9'd1;

  // port a holds entry at pos, port b entry at pos + 1
  bms_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (item.idx[STORE_AW-1:0]),
    .wr_data   (wr_entry),
    .rd_addr_a (pos_nxt[STORE_AW-1:0]),
    .rd_data_a (cur_raw),
    .rd_addr_b (rd_b_pos[STORE_AW-1:0]),
    .rd_data_b (next_raw)
  );

  assign pos_inc     = pos_r + 9'd1;
  assign cur_ok      = ({23'd0, pos_r} < 32'(STORE_DEPTH));
  assign next_ok     = ({23'd0, pos_inc} < 32'(STORE_DEPTH));
  assign cur_dur     = cur_ok ? cur_raw.dur : '0;
  assign next_note   = next_ok ? next_raw.note : '0;
  assign elapsed_inc = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;

  always_comb begin
    pos_nxt     = pos_r;
    elapsed_nxt = elapsed_r;
    total_nxt   = total_r;
    active_nxt  = active_r;
    period_nxt  = period_r;
    compare_nxt = compare_r;
    e0_nxt      = e0_r;
    fin         = 1'b0;
    if (go) begin
      unique case (item.req)
        REQ_LOAD: begin
          if (item.idx == 8'd0) begin
            e0_nxt = wr_entry;
          end
        end
        REQ_START: begin
          total_nxt   = item.cnt;
          pos_nxt     = '0;
          elapsed_nxt = '0;
          active_nxt  = 1'b1;
          if (e0_r.note != REST_NOTE) begin
            period_nxt  = TONE_PERIOD[e0_r.note];
            compare_nxt = TONE_PERIOD[e0_r.note] >> 1;
          end
        end
        REQ_STOP: begin
          active_nxt  = 1'b0;
          compare_nxt = '0;
        end
        REQ_TICK: begin
          if (active_r) begin
            elapsed_nxt = elapsed_inc;
            if (elapsed_inc >= cur_dur) begin
              pos_nxt = pos_inc;
              if (pos_inc >= total_r) begin
                active_nxt  = 1'b0;
                compare_nxt = '0;
                fin         = 1'b1;
              end else begin
                elapsed_nxt = '0;
                if (next_note != REST_NOTE) begin
                  period_nxt  = TONE_PERIOD[next_note];
                  compare_nxt = TONE_PERIOD[next_note] >> 1;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      elapsed_r <= '0;
      total_r   <= '0;
      active_r  <= 1'b0;
      period_r  <= '0;
      compare_r <= '0;
    end else begin
      pos_r     <= pos_nxt;
      elapsed_r <= elapsed_nxt;
      total_r   <= total_nxt;
      active_r  <= active_nxt;
      period_r  <= period_nxt;
      compare_r <= compare_nxt;
    end
    e0_r <= e0_nxt;
  end

  assign res = '{playing: active_nxt, period: period_nxt, compare: compare_nxt,
                 position: pos_nxt, finished: fin};

`ifndef SYNTH
  // a running melody never sits past its note count
  a_pos_in_count: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (pos_r <= total_r))
    else $error("position beyond note count while playing");

  // a start always restarts the millisecond count
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (go && item.req == REQ_START) |=> (elapsed_r == 16'd0 && pos_r == 9'd0))
    else $error("start did not clear position and elapsed time");

  // a stop silences the buzzer
  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (go && item.req == REQ_STOP) |=> (!active_r && compare_r == 16'd0))
    else $error("stop did not clear playing and compare");
`endif

endmodule

// ===== sim/tb_buzzer_melody_sequencer_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_buzzer_melody_sequencer_unit: self-checking bench for the melody sequencer
// loads note store entries, plays melodies by start/tick/stop words and checks
// every result word against a cycle-free model of the player, with random
// stalls on both channels
// ----------------------------------------------------------------------------
module tb_buzzer_melody_sequencer_unit;
  import bms_pkg::*;

  // rough size of the random part, in request words
  localparam int WORD_GOAL   = 1900;
  // cycles without any handshake before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  // drain time after the last word, to catch stray words
  localparam int DRAIN_CYCLES = 12;
  // window of cycles with no idling on either side
  localparam int CALM_FROM = 800;
  localparam int CALM_TO   = 1300;

  // tone frequencies in centihertz, C5..B5
  localparam longint unsigned TONE_CENTIHZ [7] = '{
    52325, 58733, 65925, 69846, 78399, 88000, 98777
  };

  logic clk;
  logic rst_n;

  bms_in_if  in_ch ();
  bms_out_if out_ch ();

  buzzer_melody_sequencer_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // player model: its own copy of the store and the playback state
  // --------------------------------------------------------------------------
  entry_t  tune_mem [STORE_DEPTH];
  pos_t    cursor;
  word16_t ms_count;
  pos_t    melody_len;
  logic    sounding;
  word16_t reload;
  word16_t duty;

  result_t tune_expect [$];

  // stimulus side bookkeeping
  item_t pending_words [$];
  item_t driven_word;
  bit    gen_loaded [STORE_DEPTH];

  int cycle_no;
  int idle_cycles;
  int words_taken;
  int results_seen;
  int finishes_seen;
  int top_position;
  int mismatch_count;

  // timer reload for a tone: clock / (prescale * f) minus one, truncated
  function automatic word16_t tone_reload(logic [2:0] n);
    longint unsigned q;
    q = (longint'(TIMER_CLOCK_HZ) * 100) / (longint'(PRESCALE_DIV) * TONE_CENTIHZ[n]);
    if (q == 0) return '0;
    if (q - 1 > 65535) return 16'hFFFF;
    return 16'(q - 1);
  endfunction

  // positions past the store read as an empty entry
  function automatic entry_t tune_at(pos_t p);
    entry_t e;
    e = '0;
    if (p < STORE_DEPTH) e = tune_mem[p[7:0]];
    return e;
  endfunction

  // a rest keeps whatever tone was sounding
  task automatic sound_tone(logic [2:0] n);
    if (n == REST_NOTE) return;
    reload = tone_reload(n);
    duty   = reload >> 1;
  endtask

  // advance the model by one accepted request word, queue the result word
  task automatic predict_word(input item_t w);
    result_t r;
    logic    fin;
    fin = 1'b0;
    case (w.req)
      REQ_LOAD: begin
        tune_mem[w.idx] = '{note: w.note, dur: w.dur};
      end
      REQ_START: begin
        // restart from entry 0, even with a zero count
        melody_len = w.cnt;
        cursor     = '0;
        ms_count   = '0;
        sounding   = 1'b1;
        sound_tone(tune_at('0).note);
      end
      REQ_STOP: begin
        // period, position and count survive a stop
        sounding = 1'b0;
        duty     = '0;
      end
      default: begin
        // millisecond tick, ignored while idle
        if (sounding) begin
          if (ms_count != 16'hFFFF) ms_count++;
          if (ms_count >= tune_at(cursor).dur) begin
            cursor = cursor + 9'd1;
            if (cursor >= melody_len) begin
              sounding = 1'b0;
              duty     = '0;
              fin      = 1'b1;
            end else begin
              ms_count = '0;
              sound_tone(tune_at(cursor).note);
            end
          end
        end
      end
    endcase
    r = '{playing: sounding, period: reload, compare: duty, position: cursor, finished: fin};
    tune_expect.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // stimulus building
  // --------------------------------------------------------------------------

  // fields a word does not use still get random values
  function automatic item_t blank_word(req_t r);
    item_t w;
    w.req  = r;
    w.idx  = 8'($urandom);
    w.note = 3'($urandom);
    w.dur  = 16'($urandom);
    w.cnt  = 9'($urandom_range(0, 256));
    return w;
  endfunction

  task automatic push_load(int idx, int note, int dur);
    item_t w;
    w      = blank_word(REQ_LOAD);
    w.idx  = 8'(idx);
    w.note = 3'(note);
    w.dur  = 16'(dur);
    gen_loaded[idx] = 1'b1;
    pending_words.push_back(w);
  endtask

  task automatic push_start(int cnt);
    item_t w;
    w     = blank_word(REQ_START);
    w.cnt = 9'(cnt);
    pending_words.push_back(w);
  endtask

  task automatic push_ctl(req_t r);
    pending_words.push_back(blank_word(r));
  endtask

  // length of the run of loaded entries from 0: a start never plays past it,
  // so no entry is ever read before it was written
  function automatic int loaded_prefix();
    int n;
    n = 0;
    while (n < STORE_DEPTH && gen_loaded[n]) n++;
    return n;
  endfunction

  // a short tune: load it, start it, tick it out with the odd stop or restart
  task automatic push_melody();
    int len;
    int ms_total;
    int d;
    len      = $urandom_range(1, 8);
    ms_total = 0;
    for (int i = 0; i < len; i++) begin
      d = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 4);
      push_load(i, $urandom_range(0, 7), d);
      ms_total += d + 1;
    end
    push_start($urandom_range(0, len));
    for (int t = 0; t < ms_total + 2; t++) begin
      case ($urandom_range(0, 39))
        0:       push_ctl(REQ_STOP);
        1:       push_start($urandom_range(0, len));
        default: push_ctl(REQ_TICK);
      endcase
    end
  endtask

  // whole store with short notes, played to the last position
  task automatic push_full_store();
    for (int i = 0; i < STORE_DEPTH; i++)
      push_load(i, $urandom_range(0, 7), $urandom_range(0, 1));
    push_start(STORE_DEPTH);
    for (int t = 0; t < 2 * STORE_DEPTH + 4; t++) push_ctl(REQ_TICK);
  endtask

  // stray words: full-range loads, stops, ticks, starts within the loaded run
  task automatic push_noise();
    case ($urandom_range(0, 3))
      0: push_load($urandom_range(0, 255), $urandom_range(0, 7), $urandom_range(0, 65535));
      1: push_start($urandom_range(0, loaded_prefix()));
      2: push_ctl(REQ_STOP);
      default: push_ctl(REQ_TICK);
    endcase
  endtask

  // random idling, switched off inside the calm window
  function automatic bit take_break();
    if (cycle_no >= CALM_FROM && cycle_no < CALM_TO) return 1'b0;
    return $urandom_range(0, 99) < 15;
  endfunction

  // --------------------------------------------------------------------------
  // driver: one request word in flight, next one only after a handshake
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_word(driven_word);
        words_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_words.size() > 0 && !take_break()) begin
          driven_word          = pending_words.pop_front();
          in_ch.valid          <= 1'b1;
          in_ch.req_type       <= driven_word.req;
          in_ch.entry_index    <= driven_word.idx;
          in_ch.entry_note     <= driven_word.note;
          in_ch.entry_duration <= driven_word.dur;
          in_ch.note_count     <= driven_word.cnt;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: compare each result word with the oldest prediction
  // --------------------------------------------------------------------------
  task automatic check_result();
    result_t want;
    if (tune_expect.size() == 0) begin
      $error("result word with nothing expected");
      mismatch_count++;
      return;
    end
    want = tune_expect.pop_front();
    if (out_ch.playing !== want.playing) begin
      $error("playing: expected %0d, got %0d", want.playing, out_ch.playing);
      mismatch_count++;
    end
    if (out_ch.period_value !== want.period) begin
      $error("period_value: expected %0d, got %0d", want.period, out_ch.period_value);
      mismatch_count++;
    end
    if (out_ch.compare_value !== want.compare) begin
      $error("compare_value: expected %0d, got %0d", want.compare, out_ch.compare_value);
      mismatch_count++;
    end
    if (out_ch.note_position !== want.position) begin
      $error("note_position: expected %0d, got %0d", want.position, out_ch.note_position);
      mismatch_count++;
    end
    if (out_ch.finished !== want.finished) begin
      $error("finished: expected %0d, got %0d", want.finished, out_ch.finished);
      mismatch_count++;
    end
    if (want.finished) finishes_seen++;
    if (int'(want.position) > top_position) top_position = int'(want.position);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_result();
        results_seen++;
      end
      out_ch.ready <= !take_break();
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long without any handshake means a hang or a lost word
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_no++;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("stalled for %0d cycles, %0d results outstanding", idle_cycles,
               tune_expect.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    clk                  = 1'b0;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.req_type       = REQ_LOAD;
    in_ch.entry_index    = '0;
    in_ch.entry_note     = '0;
    in_ch.entry_duration = '0;
    in_ch.note_count     = '0;
    out_ch.ready         = 1'b0;
    cursor     = '0;
    ms_count   = '0;
    melody_len = '0;
    sounding   = 1'b0;
    reload     = '0;
    duty       = '0;

    // directed: idle tick and stop, zero count, every note, restart, stop
    push_ctl(REQ_TICK);
    push_ctl(REQ_STOP);
    push_load(0, 0, 0);
    push_start(0);
    push_ctl(REQ_TICK);
    for (int i = 1; i < 8; i++) push_load(i, i, 0);
    push_load(255, REST_NOTE, 65535);
    push_start(8);
    repeat (3) push_ctl(REQ_TICK);
    push_start(2);
    push_ctl(REQ_STOP);
    push_start(8);
    repeat (8) push_ctl(REQ_TICK);

    // random part, mostly well-formed tunes
    while (pending_words.size() < WORD_GOAL) begin
      if (pending_words.size() > WORD_GOAL / 3 && loaded_prefix() < STORE_DEPTH) begin
        push_full_store();
      end else if ($urandom_range(0, 99) < 75) begin
        push_melody();
      end else begin
        push_noise();
      end
    end

    // one longer note, then one more tick
    push_load(0, $urandom_range(0, 6), 60);
    push_start(1);
    repeat (61) push_ctl(REQ_TICK);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_ch.valid || tune_expect.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d request words, checked %0d result words", words_taken, results_seen);
    $display("tunes run to their end: %0d, furthest note position: %0d", finishes_seen,
             top_position);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
